[sv/gef_pkg.sv]
// Package for the glowing-edges gradient filter.
// Holds the channel payload structs, pixel/column types and the CSR and opcode constants.
// No dependencies; imported by glowing_edges_gradient_filter.
package gef_pkg;

   // field widths fixed by the stream format
   localparam int PIX_W      = 8;
   localparam int CFG_W      = 13;
   localparam int WT_W       = 4;
   localparam int ROW_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 2;

   // register reset values
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [WT_W-1:0]  WEIGHT_RESET = 4'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_WEIGHT  = 2'd2;

   // item opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic             op;
      logic [PIX_W-1:0] ch0;
      logic [PIX_W-1:0] ch1;
      logic [PIX_W-1:0] ch2;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_ch0;
      logic [PIX_W-1:0] out_ch1;
      logic [PIX_W-1:0] out_ch2;
      logic             end_of_line;
      logic             end_of_frame;
   } rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0] ch0;
      logic [PIX_W-1:0] ch1;
      logic [PIX_W-1:0] ch2;
   } pix_type;

   // one window column: line above, centre line, line below
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } column_type;

   // control carried alongside an item in the input stage
   typedef struct packed {
      logic            emit;      // item produces a result
      logic            left_mir;  // left column mirrored from the right
      logic            right_mir; // right column mirrored from the left (also end of line)
      logic            top_mir;   // upper line mirrored from the lower
      logic            flush;     // drain item: lower line mirrored from the upper
      logic            eof;       // last result of the frame
      logic [WT_W-1:0] weight;
   } stage_ctl_type;

endpackage

[sv/glowing_edges_gradient_filter.sv]
// Top level of the 3x3 glowing-edges gradient filter: line store, window and output stage.
// Depends on gef_pkg for payload structs, window types and CSR/opcode constants.
//
// Usage:
//   req_* carries a raster stream of three-channel pixels (op = pixel) followed, once the
//   frame is complete, by width+1 flush transfers (op = flush) that drain the last results.
//   rsp_* returns one edge pixel per transfer that has a result; results trail the input
//   by one line plus one pixel, with end_of_line / end_of_frame flags.
//   csr_* writes image_width, image_height and side_weight; the values are sampled when the
//   first pixel of a frame is taken, so writes during a frame apply to the next one.
// Timing:
//   One transfer per clock is taken sustained while rsp_stall holds back no result. A result is
//   registered in the input stage with the line store read when its transfer is taken,
//   then in the result register with the kernel arithmetic when it leaves that stage.
//   The line store is a four-line ring, written at one address and read at two per cycle.
// Reset:
//   Synchronous reset empties both stages and returns the counters to the start of a frame;
//   the line store is not cleared (every entry is written before it is used).
// Back-pressure:
//   While rsp_stall holds a result, the input stage still takes items that produce no
//   result; req_stall rises only when the input stage holds a result-producing item that
//   cannot move into the occupied result register.
module glowing_edges_gradient_filter
   import gef_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   // input channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // configuration
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CAW       = $clog2(MAX_WIDTH);
   localparam int FW        = $clog2(MAX_WIDTH + 1);
   localparam int CW        = (FW > CFG_W) ? FW : CFG_W;
   localparam int MEM_AW    = CAW + 2;
   localparam int MEM_DEPTH = 4 * (1 << CAW);

   // configuration registers
   logic [CFG_W-1:0] csr_width_ff;
   logic [CFG_W-1:0] csr_height_ff;
   logic [WT_W-1:0]  csr_weight_ff;

   // frame position and latched frame geometry
   logic [CAW-1:0]   col_ff,      col_in;
   logic [ROW_W-1:0] row_ff,      row_in;
   logic [FW-1:0]    flush_ff,    flush_in;
   logic [FW-1:0]    frame_w_ff,  frame_w_in;
   logic [ROW_W-1:0] frame_h_ff,  frame_h_in;
   logic [WT_W-1:0]  frame_wt_ff, frame_wt_in;

   // input stage
   logic          s1_valid_ff, s1_valid_in;
   stage_ctl_type s1_ctl_ff,   s1_ctl_in;
   pix_type       s1_pix_ff;
   pix_type       rd_top_ff;
   pix_type       rd_mid_ff;

   // window history: previous two columns
   column_type hist1_ff;
   column_type hist2_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   // line store
   pix_type line_mem [0:MEM_DEPTH-1];

   logic             req_take;
   logic             frame_start;
   logic             pix_go;
   logic             flush_go;
   logic             item_go;
   logic             s1_adv;
   logic [FW-1:0]    width_clamped;
   logic [ROW_W-1:0] height_clamped;
   logic [CW-1:0]    width_wide;
   logic [FW-1:0]    eff_w;
   logic [CAW-1:0]   rd_col;
   logic [1:0]       slot_wr;
   logic [1:0]       slot_mid;
   logic [1:0]       slot_top;
   logic [MEM_AW-1:0] addr_wr;
   logic [MEM_AW-1:0] addr_mid;
   logic [MEM_AW-1:0] addr_top;
   pix_type          pix_in;
   column_type       col_vec;
   column_type       win_l;
   column_type       win_c;
   column_type       win_r;

   // one channel of the kernel: (|gx| + |gy|) / 2, half to even, saturated
   function automatic logic [PIX_W-1:0] edge_value(
      input logic [PIX_W-1:0] lt, input logic [PIX_W-1:0] lm, input logic [PIX_W-1:0] lb,
      input logic [PIX_W-1:0] ct, input logic [PIX_W-1:0] cb,
      input logic [PIX_W-1:0] rt, input logic [PIX_W-1:0] rm, input logic [PIX_W-1:0] rb,
      input logic [WT_W-1:0]  w
   );
      logic [12:0]        xpos, xneg, ypos, yneg;
      logic signed [13:0] gx, gy;
      logic [12:0]        ax, ay;
      logic [13:0]        s;
      logic [12:0]        h;
      xpos = 13'(lb) + 13'(w) * 13'(cb) + 13'(rb);
      xneg = 13'(lt) + 13'(w) * 13'(ct) + 13'(rt);
      ypos = 13'(rt) + 13'(w) * 13'(rm) + 13'(rb);
      yneg = 13'(lt) + 13'(w) * 13'(lm) + 13'(lb);
      gx   = $signed({1'b0, xpos}) - $signed({1'b0, xneg});
      gy   = $signed({1'b0, ypos}) - $signed({1'b0, yneg});
      ax   = gx[13] ? 13'(-gx) : gx[12:0];
      ay   = gy[13] ? 13'(-gy) : gy[12:0];
      s    = 14'(ax) + 14'(ay);
      h    = s[13:1];
      if (s[0] && h[0]) begin
         h = h + 13'd1;
      end
      return (h > 13'd255) ? {PIX_W{1'b1}} : h[PIX_W-1:0];
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= WIDTH_RESET;
         csr_height_ff <= HEIGHT_RESET;
         csr_weight_ff <= WEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  csr_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: csr_height_ff <= csr_wdata;
            CSR_SIDE_WEIGHT:  csr_weight_ff <= csr_wdata[WT_W-1:0];
            default: ;
         endcase
      end
   end

   // frame geometry clamped to what the line store can hold
   always_comb begin
      width_wide = CW'(csr_width_ff);
      if (width_wide < CW'(MIN_DIM)) begin
         width_clamped = FW'(MIN_DIM);
      end else if (width_wide > CW'(MAX_WIDTH)) begin
         width_clamped = FW'(MAX_WIDTH);
      end else begin
         width_clamped = FW'(width_wide);
      end
      if (csr_height_ff < ROW_W'(MIN_DIM)) begin
         height_clamped = ROW_W'(MIN_DIM);
      end else if (csr_height_ff > ROW_W'(MAX_HEIGHT)) begin
         height_clamped = ROW_W'(MAX_HEIGHT);
      end else begin
         height_clamped = csr_height_ff;
      end
   end

   // handshake and item classification
   assign s1_adv    = s1_valid_ff && (!s1_ctl_ff.emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   assign frame_start = (req_data.op == OP_PIXEL) && (row_ff == '0) && (col_ff == '0)
                        && (flush_ff == '0);
   assign eff_w    = frame_start ? width_clamped : frame_w_ff;
   assign pix_go   = req_take && (req_data.op == OP_PIXEL)
                     && (frame_start || (row_ff < frame_h_ff));
   assign flush_go = req_take && (req_data.op == OP_FLUSH) && (row_ff >= frame_h_ff);
   assign item_go  = pix_go || flush_go;

   always_comb begin
      pix_in.ch0 = req_data.ch0;
      pix_in.ch1 = req_data.ch1;
      pix_in.ch2 = req_data.ch2;
   end

   // counters, frame latch and input-stage control
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      flush_in    = flush_ff;
      frame_w_in  = frame_w_ff;
      frame_h_in  = frame_h_ff;
      frame_wt_in = frame_wt_ff;
      s1_ctl_in   = s1_ctl_ff;

      if (pix_go) begin
         if (frame_start) begin
            frame_w_in  = width_clamped;
            frame_h_in  = height_clamped;
            frame_wt_in = csr_weight_ff;
         end
         if (FW'(col_ff) + FW'(1) == eff_w) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CAW'(1);
         end
         s1_ctl_in.emit      = (row_ff != '0) && !((row_ff == ROW_W'(1)) && (col_ff == '0));
         s1_ctl_in.left_mir  = (col_ff == CAW'(1));
         s1_ctl_in.right_mir = (col_ff == '0);
         s1_ctl_in.top_mir   = (row_ff == ROW_W'(1));
         s1_ctl_in.flush     = 1'b0;
         s1_ctl_in.eof       = 1'b0;
         s1_ctl_in.weight    = frame_start ? csr_weight_ff : frame_wt_ff;
      end else if (flush_go) begin
         if (flush_ff == frame_w_ff) begin
            flush_in = '0;
            row_in   = '0;
            col_in   = '0;
         end else begin
            flush_in = flush_ff + FW'(1);
         end
         s1_ctl_in.emit      = 1'b1;
         s1_ctl_in.left_mir  = (flush_ff == FW'(1));
         s1_ctl_in.right_mir = (flush_ff == '0) || (flush_ff == frame_w_ff);
         s1_ctl_in.top_mir   = 1'b0;
         s1_ctl_in.flush     = 1'b1;
         s1_ctl_in.eof       = (flush_ff == frame_w_ff);
         s1_ctl_in.weight    = frame_wt_ff;
      end

      if (item_go) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         flush_ff    <= '0;
         frame_w_ff  <= FW'(MIN_DIM);  // settled by the first pixel of a frame
         frame_h_ff  <= HEIGHT_RESET;
         frame_wt_ff <= WEIGHT_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         flush_ff    <= flush_in;
         frame_w_ff  <= frame_w_in;
         frame_h_ff  <= frame_h_in;
         frame_wt_ff <= frame_wt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // line store addressing: ring slot from the low row bits, column from the position
   assign rd_col   = (req_data.op == OP_FLUSH) ? flush_ff[CAW-1:0] : col_ff;
   assign slot_wr  = row_ff[1:0];
   assign slot_mid = row_ff[1:0] - 2'd1;
   assign slot_top = row_ff[1:0] - 2'd2;
   assign addr_wr  = {slot_wr, col_ff};
   assign addr_mid = {slot_mid, rd_col};
   assign addr_top = {slot_top, rd_col};

   // line store: one write, two registered reads
   always_ff @(posedge clock) begin
      if (pix_go) begin
         line_mem[addr_wr] <= pix_in;
      end
      if (item_go) begin
         rd_top_ff <= line_mem[addr_top];
         rd_mid_ff <= line_mem[addr_mid];
      end
   end

   // input-stage payload
   always_ff @(posedge clock) begin
      if (item_go) begin
         s1_pix_ff <= pix_in;
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   // new column with vertical mirroring, then the 3x3 window
   always_comb begin
      col_vec.mid = rd_mid_ff;
      col_vec.bot = s1_ctl_ff.flush ? rd_top_ff : s1_pix_ff;
      col_vec.top = s1_ctl_ff.top_mir ? col_vec.bot : rd_top_ff;
      win_l = s1_ctl_ff.left_mir ? col_vec : hist2_ff;
      win_c = hist1_ff;
      win_r = s1_ctl_ff.right_mir ? hist2_ff : col_vec;
   end

   // kernel per channel into the result register
   always_comb begin
      rsp_data_in.out_ch0 = edge_value(win_l.top.ch0, win_l.mid.ch0, win_l.bot.ch0,
                                       win_c.top.ch0, win_c.bot.ch0,
                                       win_r.top.ch0, win_r.mid.ch0, win_r.bot.ch0,
                                       s1_ctl_ff.weight);
      rsp_data_in.out_ch1 = edge_value(win_l.top.ch1, win_l.mid.ch1, win_l.bot.ch1,
                                       win_c.top.ch1, win_c.bot.ch1,
                                       win_r.top.ch1, win_r.mid.ch1, win_r.bot.ch1,
                                       s1_ctl_ff.weight);
      rsp_data_in.out_ch2 = edge_value(win_l.top.ch2, win_l.mid.ch2, win_l.bot.ch2,
                                       win_c.top.ch2, win_c.bot.ch2,
                                       win_r.top.ch2, win_r.mid.ch2, win_r.bot.ch2,
                                       s1_ctl_ff.weight);
      rsp_data_in.end_of_line  = s1_ctl_ff.right_mir;
      rsp_data_in.end_of_frame = s1_ctl_ff.eof;

      if (s1_adv && s1_ctl_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // window history shifts once per item leaving the input stage
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         hist2_ff <= hist1_ff;
         hist1_ff <= col_vec;
      end
      if (s1_adv && s1_ctl_ff.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the glowing-edges gradient filter.
// Drives raster frames and drain transfers, predicts every edge pixel and checks each one.
// Depends on gef_pkg and glowing_edges_gradient_filter.
module testbench
   import gef_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W        = 4096;
   localparam int RANDOM_ITEMS = 1450;
   localparam int SETTLE       = 6;        // cycles after the last result before a register write
   localparam int CYCLE_LIMIT  = 600000;
   localparam int QUIET_START  = 600;      // window with no idling on either side
   localparam int QUIET_END    = 1200;
   localparam int HOLD_CYCLES  = 120;      // long receiver hold-off
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   // stimulus and expected edge pixels
   req_type     stream_items [$];
   rsp_type     edges_due [$];
   int          mismatches   = 0;
   int          edges_seen   = 0;
   int          hold_left    = 0;
   bit          hold_done    = 1'b0;
   int          random_items = 0;
   int unsigned cycle_count  = 0;
   logic        quiet;

   // register copies and the filter state as the predictor sees it
   logic [CFG_W-1:0] reg_width  = WIDTH_RESET;
   logic [CFG_W-1:0] reg_height = HEIGHT_RESET;
   logic [WT_W-1:0]  reg_weight = WEIGHT_RESET;
   pix_type          ring_lines [4][MAX_W];
   int unsigned      next_col    = 0;
   int unsigned      next_row    = 0;
   int unsigned      drains_done = 0;
   int unsigned      cur_w       = 640;
   int unsigned      cur_h       = 480;
   int unsigned      cur_wt      = 3;

   assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

   glowing_edges_gradient_filter #(.MAX_WIDTH(MAX_W)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Edge brightness of output position o, reflect-101 at all four borders
   function automatic rsp_type edge_pixel(int unsigned o);
      int          ro, co, pos, gx, gy, s, h, w, i, j, c, d;
      int unsigned rsel [3];
      int unsigned csel [3];
      int          win [3][3];
      logic [7:0]  lanes [3];
      rsp_type     r;
      ro = o / cur_w;
      co = o % cur_w;
      for (d = 0; d < 3; d++) begin
         pos = ro + d - 1;
         rsel[d] = ((pos < 0) ? 1 : (pos >= int'(cur_h)) ? cur_h - 2 : pos) % 4;
         pos = co + d - 1;
         csel[d] = (pos < 0) ? 1 : (pos >= int'(cur_w)) ? cur_w - 2 : pos;
      end
      w = cur_wt;
      for (c = 0; c < 3; c++) begin
         for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
               win[i][j] = ring_lines[rsel[i]][csel[j]][8*(2-c) +: 8];
         gx = (win[2][0] + w*win[2][1] + win[2][2]) - (win[0][0] + w*win[0][1] + win[0][2]);
         gy = (win[0][2] + w*win[1][2] + win[2][2]) - (win[0][0] + w*win[1][0] + win[2][0]);
         s = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
         h = s / 2;
         // halves go to the even neighbour
         if ((s % 2 == 1) && (h % 2 == 1))
            h++;
         if (h > 255)
            h = 255;
         lanes[c] = 8'(h);
      end
      r.out_ch0      = lanes[0];
      r.out_ch1      = lanes[1];
      r.out_ch2      = lanes[2];
      r.end_of_line  = (co == cur_w - 1);
      r.end_of_frame = (o == cur_w * cur_h - 1);
      return r;
   endfunction

   // Advance the predicted filter by one accepted transfer
   task automatic filter_step(input req_type item);
      int unsigned k, wv, hv;
      if (item.op == OP_PIXEL) begin
         // frame geometry and weight are latched on the first pixel
         if (next_row == 0 && next_col == 0 && drains_done == 0) begin
            wv = reg_width;
            hv = reg_height;
            cur_w  = (wv < MIN_DIM) ? MIN_DIM : (wv > MAX_W) ? MAX_W : wv;
            cur_h  = (hv < MIN_DIM) ? MIN_DIM : (hv > MAX_HEIGHT) ? MAX_HEIGHT : hv;
            cur_wt = reg_weight;
         end
         // pixels past a complete frame are dropped
         if (next_row < cur_h) begin
            ring_lines[next_row % 4][next_col] = {item.ch0, item.ch1, item.ch2};
            k = next_row * cur_w + next_col;
            next_col++;
            if (next_col == cur_w) begin
               next_col = 0;
               next_row++;
            end
            if (k >= cur_w + 1)
               edges_due.push_back(edge_pixel(k - cur_w - 1));
         end
      end else if (next_row >= cur_h) begin
         // drain; a flush during the frame does nothing
         edges_due.push_back(edge_pixel(cur_h * cur_w - cur_w - 1 + drains_done));
         drains_done++;
         if (drains_done == cur_w + 1) begin
            drains_done = 0;
            next_row    = 0;
            next_col    = 0;
         end
      end
   endtask

   // Input driver: offers queued items, holds a stalled transfer unchanged
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            filter_step(req_data);
         if (!req_valid || !req_stall) begin
            if (stream_items.size() != 0 && (quiet || $urandom_range(99) >= 11)) begin
               req_valid <= 1'b1;
               req_data  <= stream_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (edges_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected edge pixel, expected none, got %p", $time, rsp_data);
            end else begin
               want = edges_due.pop_front();
               if (rsp_data.out_ch0 !== want.out_ch0 || rsp_data.out_ch1 !== want.out_ch1 ||
                   rsp_data.out_ch2 !== want.out_ch2 ||
                   rsp_data.end_of_line !== want.end_of_line ||
                   rsp_data.end_of_frame !== want.end_of_frame) begin
                  mismatches++;
                  $display("%0t: edge pixel mismatch, expected %p, got %p",
                           $time, want, rsp_data);
               end
            end
            edges_seen++;
            // once, with plenty still queued, hold off long enough to back the block up
            if (!hold_done && edges_seen >= 300 && stream_items.size() >= 16) begin
               hold_left = HOLD_CYCLES;
               hold_done = 1'b1;
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 11);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_type make_item(logic op, logic [7:0] c0, logic [7:0] c1,
                                         logic [7:0] c2);
      req_type r;
      r.op  = op;
      r.ch0 = c0;
      r.ch1 = c1;
      r.ch2 = c2;
      return r;
   endfunction

   function automatic req_type random_item(logic op, bit binary);
      if (binary)
         return make_item(op, {8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                          {8{1'($urandom_range(1))}});
      return make_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
   endfunction

   // One register write; the caller lowers the enable after the last one
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_IMAGE_WIDTH:  reg_width  = value;
         CSR_IMAGE_HEIGHT: reg_height = value;
         CSR_SIDE_WEIGHT:  reg_weight = value[WT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_filter(input logic [CFG_W-1:0] w_raw, h_raw, wt_raw);
      write_reg(CSR_IMAGE_WIDTH, w_raw);
      write_reg(CSR_IMAGE_HEIGHT, h_raw);
      write_reg(CSR_SIDE_WEIGHT, wt_raw);
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Sender pause: every item taken, every result back, pipeline settled
   task automatic wait_drained();
      do
         @(negedge clock);
      while (stream_items.size() != 0 || req_valid || edges_due.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   // A complete frame plus its drain, with the odd stray transfer mixed in
   task automatic queue_frame(input logic [CFG_W-1:0] w_raw, h_raw, wt_raw,
                              input bit binary, input bit split);
      int unsigned wd, ht, n, cut;
      program_filter(w_raw, h_raw, wt_raw);
      wd  = (w_raw < MIN_DIM) ? MIN_DIM : (w_raw > MAX_W) ? MAX_W : w_raw;
      ht  = (h_raw < MIN_DIM) ? MIN_DIM : (h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw;
      cut = split ? $urandom_range(1, wd * ht - 1) : 0;
      for (n = 0; n < wd * ht; n++) begin
         // registers rewritten mid-frame only count from the next frame
         if (split && n == cut) begin
            wait_drained();
            program_filter(13'($urandom), 13'($urandom), 13'($urandom));
         end
         if ($urandom_range(99) < 3)
            stream_items.push_back(random_item(OP_FLUSH, 1'b0));
         stream_items.push_back(random_item(OP_PIXEL, binary));
      end
      if ($urandom_range(99) < 15)
         repeat ($urandom_range(1, 3)) stream_items.push_back(random_item(OP_PIXEL, 1'b0));
      for (n = 0; n <= wd; n++)
         stream_items.push_back(random_item(OP_FLUSH, 1'b0));
      random_items += wd * ht + wd + 1;
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // smallest frame, widest weight, clamped geometry, unknown register index
      write_reg(CSR_IMAGE_WIDTH, 13'd1);
      write_reg(CSR_IMAGE_HEIGHT, 13'd0);
      write_reg(CSR_SIDE_WEIGHT, 13'h1FFF);
      write_reg(CSR_UNUSED, 13'h0AAA);
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      stream_items.push_back(make_item(OP_PIXEL, 8'h00, 8'hFF, 8'h80));
      stream_items.push_back(make_item(OP_FLUSH, 8'hAA, 8'h55, 8'h01)); // early flush
      stream_items.push_back(make_item(OP_PIXEL, 8'hFF, 8'h00, 8'h7F));
      stream_items.push_back(make_item(OP_PIXEL, 8'hFF, 8'hFF, 8'h00));
      stream_items.push_back(make_item(OP_PIXEL, 8'h00, 8'h00, 8'hFF));
      stream_items.push_back(make_item(OP_PIXEL, 8'h12, 8'h34, 8'h56)); // past full frame
      stream_items.push_back(make_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF));
      stream_items.push_back(make_item(OP_FLUSH, 8'h00, 8'h00, 8'h00));
      stream_items.push_back(make_item(OP_FLUSH, 8'h5A, 8'hA5, 8'hC3));
      stream_items.push_back(make_item(OP_FLUSH, 8'hFF, 8'h00, 8'hFF)); // after drain
      wait_drained();

      // 3x2 frame with zero side weight
      program_filter(13'd3, 13'd2, 13'd0);
      stream_items.push_back(make_item(OP_PIXEL, 8'hFF, 8'h00, 8'hFF));
      stream_items.push_back(make_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00));
      stream_items.push_back(make_item(OP_PIXEL, 8'hFF, 8'hFF, 8'h01));
      stream_items.push_back(make_item(OP_PIXEL, 8'h00, 8'h00, 8'hFE));
      stream_items.push_back(make_item(OP_PIXEL, 8'hFF, 8'h80, 8'h7F));
      stream_items.push_back(make_item(OP_PIXEL, 8'h01, 8'hFF, 8'h00));
      repeat (4) stream_items.push_back(make_item(OP_FLUSH, 8'h00, 8'hFF, 8'h00));
      wait_drained();

      // mostly small random frames
      while (random_items < RANDOM_ITEMS)
         queue_frame(($urandom_range(9) == 0) ? 13'($urandom_range(13, 40))
                                              : 13'($urandom_range(0, 12)),
                     ($urandom_range(9) == 0) ? 13'($urandom_range(9, 16))
                                              : 13'($urandom_range(0, 8)),
                     13'($urandom), $urandom_range(3) == 0, $urandom_range(7) == 0);

      if (mismatches == 0 && edges_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
